// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define VPA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define VPA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/vpa_pkg.sv =====
// ----------------------------------------------------------------------------
// vpa_pkg
// Constants, types and the arctangent table of the vector pair angle unit.
// ----------------------------------------------------------------------------
package vpa_pkg;

	localparam int COORD_BITS_DEF      = 16;
	localparam int ANGLE_FRAC_BITS_DEF = 13;

	// Angle accumulator: Q4.30, signed with headroom.
	localparam int ZFRAC = 30;
	localparam int Z_W   = 34;

	localparam int CORDIC_ITERS = 28;

	// The normalizer brings the larger component into [2^NORM_TOP, 2^(NORM_TOP+1)).
	localparam int NORM_TOP = 57;
	localparam int NRM_W    = NORM_TOP + 1;
	localparam int SH_W     = $clog2(NRM_W);

	// CORDIC datapath width; gain and sign leave room above NRM_W.
	localparam int XY_W = NRM_W + 4;

	localparam logic signed [Z_W-1:0] HALF_PI_Q30 = Z_W'(64'd1686629713);
	localparam logic signed [Z_W-1:0] PI_Q30      = Z_W'(64'd3373259426);

	typedef struct packed {
		logic                    vld;
		logic                    degen;
		logic signed [XY_W-1:0]  x;
		logic signed [XY_W-1:0]  y;
		logic signed [Z_W-1:0]   z;
	} cordic_t;

	// Truncated atan(2^-i) in Q4.30; the last entry, i = 27, is rounded up to 8.
	function automatic logic signed [Z_W-1:0] atan_q30(input int i);
		logic signed [Z_W-1:0] r;
		case (i)
			0:       r = Z_W'(64'd843314856);
			1:       r = Z_W'(64'd497837829);
			2:       r = Z_W'(64'd263043836);
			3:       r = Z_W'(64'd133525158);
			4:       r = Z_W'(64'd67021686);
			5:       r = Z_W'(64'd33543515);
			6:       r = Z_W'(64'd16775850);
			7:       r = Z_W'(64'd8388437);
			8:       r = Z_W'(64'd4194282);
			9:       r = Z_W'(64'd2097149);
			10:      r = Z_W'(64'd1048575);
			11:      r = Z_W'(64'd524287);
			12:      r = Z_W'(64'd262143);
			13:      r = Z_W'(64'd131071);
			14:      r = Z_W'(64'd65535);
			15:      r = Z_W'(64'd32767);
			16:      r = Z_W'(64'd16383);
			17:      r = Z_W'(64'd8191);
			18:      r = Z_W'(64'd4095);
			19:      r = Z_W'(64'd2047);
			20:      r = Z_W'(64'd1023);
			21:      r = Z_W'(64'd511);
			22:      r = Z_W'(64'd255);
			23:      r = Z_W'(64'd127);
			24:      r = Z_W'(64'd63);
			25:      r = Z_W'(64'd31);
			26:      r = Z_W'(64'd15);
			27:      r = Z_W'(64'd8);
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ===== hw/rtl/vpa_seg_if.sv =====
// ----------------------------------------------------------------------------
// vpa_seg_if
// Segment pair channel: two segments as eight signed coordinates.
// ----------------------------------------------------------------------------
interface vpa_seg_if #(
	parameter int COORD_BITS = vpa_pkg::COORD_BITS_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] first_start_x;
	logic signed [COORD_BITS-1:0] first_start_y;
	logic signed [COORD_BITS-1:0] first_end_x;
	logic signed [COORD_BITS-1:0] first_end_y;
	logic signed [COORD_BITS-1:0] second_start_x;
	logic signed [COORD_BITS-1:0] second_start_y;
	logic signed [COORD_BITS-1:0] second_end_x;
	logic signed [COORD_BITS-1:0] second_end_y;

	modport source (
		output valid, first_start_x, first_start_y, first_end_x, first_end_y,
		       second_start_x, second_start_y, second_end_x, second_end_y,
		input  ready
	);
	modport sink (
		input  valid, first_start_x, first_start_y, first_end_x, first_end_y,
		       second_start_x, second_start_y, second_end_x, second_end_y,
		output ready
	);
endinterface

// ===== hw/rtl/vpa_ang_if.sv =====
// ----------------------------------------------------------------------------
// vpa_ang_if
// Angle result channel: unsigned fixed-point radians and a degenerate flag.
// ----------------------------------------------------------------------------
interface vpa_ang_if #(
	parameter int ANGLE_FRAC_BITS = vpa_pkg::ANGLE_FRAC_BITS_DEF
);
	logic                       valid;
	logic                       ready;
	logic [ANGLE_FRAC_BITS+1:0] angle_rad;
	logic                       degenerate;

	modport source (
		output valid, angle_rad, degenerate,
		input  ready
	);
	modport sink (
		input  valid, angle_rad, degenerate,
		output ready
	);
endinterface

// ===== hw/rtl/vpa_cordic_stage.sv =====
// ----------------------------------------------------------------------------
// vpa_cordic_stage
// One registered vectoring CORDIC iteration with a fixed shift.
// ----------------------------------------------------------------------------
module vpa_cordic_stage #(
	parameter int ITER = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  vpa_pkg::cordic_t  d,
	output vpa_pkg::cordic_t  q
);
	import vpa_pkg::*;

	logic signed [XY_W-1:0] xs;
	logic signed [XY_W-1:0] ys;
	logic signed [XY_W-1:0] x_nxt;
	logic signed [XY_W-1:0] y_nxt;
	logic signed [Z_W-1:0]  z_nxt;
	logic                   vld_q;
	logic                   degen_q;
	logic signed [XY_W-1:0] x_q;
	logic signed [XY_W-1:0] y_q;
	logic signed [Z_W-1:0]  z_q;

	assign xs = d.x;
	assign ys = d.y;

	// Rotate toward the x axis; the arithmetic shift rounds toward minus infinity.
	always_comb begin
		if (!ys[XY_W-1]) begin
			x_nxt = xs + (ys >>> ITER);
			y_nxt = ys - (xs >>> ITER);
			z_nxt = d.z + atan_q30(ITER);
		end else begin
			x_nxt = xs - (ys >>> ITER);
			y_nxt = ys + (xs >>> ITER);
			z_nxt = d.z - atan_q30(ITER);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= d.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			degen_q <= d.degen;
			x_q     <= x_nxt;
			y_q     <= y_nxt;
			z_q     <= z_nxt;
		end
	end

	always_comb begin
		q.vld   = vld_q;
		q.degen = degen_q;
		q.x     = x_q;
		q.y     = y_q;
		q.z     = z_q;
	end

endmodule

// ===== hw/rtl/vector_pair_angle_unit.sv =====
// An accepted item passes the front stages, the CORDIC stages and the output register.
// Throughput: one item per cycle when not stalled; 28 CORDIC iterations, a stage each.
// A stalled output holds the whole pipeline in place; nothing is dropped.
// Reset (arst_n low) clears all valid bits at once; the unit is ready after release.
// ----------------------------------------------------------------------------
// vector_pair_angle_unit
// Angle in [0, pi] between two segment direction vectors, from atan2 of
// |cross| and dot with a normalizer and an unrolled vectoring CORDIC.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vector_pair_angle_unit #(
	parameter int COORD_BITS      = vpa_pkg::COORD_BITS_DEF,
	parameter int ANGLE_FRAC_BITS = vpa_pkg::ANGLE_FRAC_BITS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	vpa_seg_if.sink    segs,
	vpa_ang_if.source  result
);
	import vpa_pkg::*;

	localparam int D_W   = COORD_BITS + 1;
	localparam int P_W   = 2 * D_W;
	localparam int S_W   = P_W + 1;
	localparam int A_W   = ANGLE_FRAC_BITS + 2;
	localparam int RSH   = ZFRAC - ANGLE_FRAC_BITS;
	localparam logic signed [Z_W-1:0] RND = Z_W'(64'd1 << (RSH - 1));
	localparam logic [Z_W-1:0] PI_OUT = (Z_W'(PI_Q30) + Z_W'(RND)) >> RSH;

	logic adv;

	// Stage 1: differences and the zero-length check.
	logic                  vld_s1;
	logic                  degen_s1;
	logic signed [D_W-1:0] ax_s1, ay_s1, bx_s1, by_s1;

	// Stage 2: products.
	logic                  vld_s2;
	logic                  degen_s2;
	logic signed [P_W-1:0] axbx_s2, ayby_s2, axby_s2, aybx_s2;

	// Stage 3: dot and cross.
	logic                  vld_s3;
	logic                  degen_s3;
	logic signed [S_W-1:0] dot_s3, cross_s3;

	// Stage 4: quadrant fold into nonnegative x, y.
	logic                  vld_s4;
	logic                  degen_s4;
	logic [S_W-1:0]        x_s4, y_s4;
	logic signed [Z_W-1:0] z_s4;
	logic signed [S_W-1:0] cross_abs;
	logic [S_W-1:0]        x_fold, y_fold;
	logic signed [Z_W-1:0] z_fold;

	// Stage 5: normalize shift amount.
	logic                  vld_s5;
	logic                  degen_s5;
	logic [S_W-1:0]        x_s5, y_s5;
	logic signed [Z_W-1:0] z_s5;
	logic [SH_W-1:0]       sh_s5;
	logic [NRM_W-1:0]      mag_or;
	logic [SH_W-1:0]       msb;

	// Stage 6: normalized operands into the CORDIC.
	logic                  vld_s6;
	logic                  degen_s6;
	logic [NRM_W-1:0]      x_s6, y_s6;
	logic signed [Z_W-1:0] z_s6;

	cordic_t cord [0:CORDIC_ITERS];

	// Output register.
	logic                  out_vld_q;
	logic                  degen_q;
	logic [A_W-1:0]        angle_q;
	logic signed [Z_W-1:0] z_clamp;
	logic [Z_W-1:0]        z_rnd;

	assign adv        = !out_vld_q || result.ready;
	assign segs.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			vld_s5    <= 1'b0;
			vld_s6    <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			vld_s1    <= segs.valid;
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			vld_s4    <= vld_s3;
			vld_s5    <= vld_s4;
			vld_s6    <= vld_s5;
			out_vld_q <= cord[CORDIC_ITERS].vld;
		end
	end

	always_comb begin
		cross_abs = cross_s3[S_W-1] ? -cross_s3 : cross_s3;
		// An obtuse pair is turned by -pi/2 so the CORDIC only sees the right half plane.
		if (dot_s3[S_W-1]) begin
			x_fold = cross_abs;
			y_fold = -dot_s3;
			z_fold = HALF_PI_Q30;
		end else begin
			x_fold = dot_s3;
			y_fold = cross_abs;
			z_fold = '0;
		end
	end

	// Both components are nonnegative, so the leading one of their OR is that of the larger.
	always_comb begin
		mag_or = NRM_W'(x_s4 | y_s4);
		msb    = '0;
		for (int i = 0; i < NRM_W; i++) begin
			if (mag_or[i]) begin
				msb = SH_W'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			degen_s1 <= (segs.first_start_x == segs.first_end_x &&
			             segs.first_start_y == segs.first_end_y) ||
			            (segs.second_start_x == segs.second_end_x &&
			             segs.second_start_y == segs.second_end_y);
			ax_s1 <= D_W'(segs.first_start_x) - D_W'(segs.first_end_x);
			ay_s1 <= D_W'(segs.first_start_y) - D_W'(segs.first_end_y);
			bx_s1 <= D_W'(segs.second_start_x) - D_W'(segs.second_end_x);
			by_s1 <= D_W'(segs.second_start_y) - D_W'(segs.second_end_y);

			degen_s2 <= degen_s1;
			axbx_s2  <= P_W'(ax_s1) * P_W'(bx_s1);
			ayby_s2  <= P_W'(ay_s1) * P_W'(by_s1);
			axby_s2  <= P_W'(ax_s1) * P_W'(by_s1);
			aybx_s2  <= P_W'(ay_s1) * P_W'(bx_s1);

			degen_s3 <= degen_s2;
			dot_s3   <= S_W'(axbx_s2) + S_W'(ayby_s2);
			cross_s3 <= S_W'(axby_s2) - S_W'(aybx_s2);

			degen_s4 <= degen_s3;
			x_s4     <= x_fold;
			y_s4     <= y_fold;
			z_s4     <= z_fold;

			degen_s5 <= degen_s4;
			x_s5     <= x_s4;
			y_s5     <= y_s4;
			z_s5     <= z_s4;
			sh_s5    <= SH_W'(NORM_TOP) - msb;

			degen_s6 <= degen_s5;
			x_s6     <= NRM_W'(x_s5) << sh_s5;
			y_s6     <= NRM_W'(y_s5) << sh_s5;
			z_s6     <= z_s5;
		end
	end

	always_comb begin
		cord[0].vld   = vld_s6;
		cord[0].degen = degen_s6;
		cord[0].x     = XY_W'(x_s6);
		cord[0].y     = XY_W'(y_s6);
		cord[0].z     = z_s6;
	end

	for (genvar g = 0; g < CORDIC_ITERS; g++) begin : g_cordic
		vpa_cordic_stage #(
			.ITER (g)
		) u_stage (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv),
			.d      (cord[g]),
			.q      (cord[g+1])
		);
	end

	always_comb begin
		if (cord[CORDIC_ITERS].z[Z_W-1]) begin
			z_clamp = '0;
		end else if (cord[CORDIC_ITERS].z > PI_Q30) begin
			z_clamp = PI_Q30;
		end else begin
			z_clamp = cord[CORDIC_ITERS].z;
		end
		z_rnd = z_clamp + RND;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			degen_q <= cord[CORDIC_ITERS].degen;
			angle_q <= cord[CORDIC_ITERS].degen ? '0 : z_rnd[RSH +: A_W];
		end
	end

	assign result.valid      = out_vld_q;
	assign result.angle_rad  = angle_q;
	assign result.degenerate = degen_q;

	`VPA_ASSERT_NOW(a_degen_zero, result.valid && result.degenerate, result.angle_rad == '0, "degenerate item with nonzero angle")
	`VPA_ASSERT_NOW(a_angle_max, result.valid, Z_W'(result.angle_rad) <= PI_OUT, "angle above pi")
	`VPA_ASSERT_NOW(a_norm_top, cord[0].vld && !cord[0].degen, cord[0].x[NORM_TOP] || cord[0].y[NORM_TOP], "normalizer missed the top bit")
	`VPA_ASSERT_NEXT(a_hold, !adv && cord[0].vld, cord[0].vld, "stalled item lost at CORDIC entry")

endmodule
